[hw/rtl/rdf_pkg.sv]
// ----------------------------------------------------------------------------
// rdf_pkg
// Shared types and constants for the radix digit formatter: sequencer states,
// configuration register indexes and the symbol validity limits.
// ----------------------------------------------------------------------------
package rdf_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_EMIT_RD,
        ST_EMIT_LD
    } rdf_state_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [1:0] CFG_SYMBOLS_HIGH = 2'd2;

    // Alphabet limits
    localparam int unsigned MAX_SYMBOLS = 16;
    localparam logic [7:0]  CHAR_PLUS   = 8'd43;   // '+'
    localparam logic [7:0]  CHAR_MINUS  = 8'd45;   // '-'
    localparam logic [7:0]  CHAR_LOWEST = 8'd33;
    localparam logic [7:0]  CHAR_HIGHEST = 8'd126;

    // Field widths
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned POS_W   = 6;

    // Reset alphabet "abcdefgh89abcdef", symbol 0 first
    localparam logic [4:0]  BASE_LENGTH_RST  = 5'd16;
    localparam logic [63:0] SYMBOLS_LOW_RST  = 64'd7523094288207667809;
    localparam logic [63:0] SYMBOLS_HIGH_RST = 64'd7378413942531504440;

endpackage

[hw/rtl/radix_digit_formatter_unit.sv]
// ----------------------------------------------------------------------------
// radix_digit_formatter_unit
// Writes an unsigned 64-bit value out as symbols of a configurable base, most
// significant digit first, one symbol per output request, last one flagged.
// ----------------------------------------------------------------------------
// One value is handled at a time. After acceptance the alphabet is checked,
// one symbol per cycle; a bad alphabet drops the value with no output. Each
// digit is then formed on a bit-serial shift-subtract divider whose
// remainder is written into the digit memory, and each digit is read back
// from that memory and then loaded into the output register, the load
// waiting while a held output request blocks it. The next value is accepted
// as soon as the final symbol sits in the output register.
// A value needing more than MAX_DIGITS digits keeps the most significant
// MAX_DIGITS of them, as the memory is written as a ring.
module radix_digit_formatter_unit #(
    parameter int unsigned MAX_DIGITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,

    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [63:0] value

    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] digit_char, [13:8] position, [15:14] zero
    output logic        m_tlast     // last_digit
);

    localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DIGITS - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_DIGITS);

    // Configuration registers
    logic [4:0]   base_len_reg;
    logic [63:0]  sym_lo_reg;
    logic [63:0]  sym_hi_reg;
    logic [127:0] sym_all;

    // Sequencer
    rdf_pkg::rdf_state_t state_reg, state_next;

    // Datapath registers
    logic [rdf_pkg::VALUE_W-1:0] q_reg;
    logic [3:0]                  rem_reg;
    logic [5:0]                  bit_cnt_reg;
    logic [3:0]                  chk_idx_reg;
    logic [AW-1:0]               wptr_reg;
    logic [AW-1:0]               raddr_reg;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               left_reg;
    logic [rdf_pkg::POS_W-1:0]   k_reg;
    logic [3:0]                  rdata_reg;

    // Output register
    logic                        m_tvalid_reg;
    logic [7:0]                  m_char_reg;
    logic [rdf_pkg::POS_W-1:0]   m_pos_reg;
    logic                        m_last_reg;

    // Digit memory, least significant digit first
    logic [3:0] digit_mem [MAX_DIGITS];

    // Strobes and combinational values
    logic                        in_accept;
    logic                        len_ok;
    logic                        out_free;
    logic                        out_load;
    logic                        div_last;
    logic                        emit_last;
    logic [7:0]                  chk_char;
    logic                        chk_dup;
    logic                        chk_bad;
    logic                        chk_done;
    logic [4:0]                  div_shift;
    logic                        div_ge;
    logic [4:0]                  div_sub;
    logic [3:0]                  rem_next;
    logic [rdf_pkg::VALUE_W-1:0] q_next;
    logic [CW-1:0]               count_next;

    assign sym_all = {sym_hi_reg, sym_lo_reg};

    // Configuration writes, always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_len_reg <= rdf_pkg::BASE_LENGTH_RST;
            sym_lo_reg   <= rdf_pkg::SYMBOLS_LOW_RST;
            sym_hi_reg   <= rdf_pkg::SYMBOLS_HIGH_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rdf_pkg::CFG_BASE_LENGTH:  base_len_reg <= cfg_data[4:0];
                rdf_pkg::CFG_SYMBOLS_LOW:  sym_lo_reg   <= cfg_data;
                rdf_pkg::CFG_SYMBOLS_HIGH: sym_hi_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Alphabet check, one symbol against all later ones per cycle
    assign len_ok   = (base_len_reg >= 5'd2) && (base_len_reg <= 5'(rdf_pkg::MAX_SYMBOLS));
    assign chk_char = sym_all[{chk_idx_reg, 3'b000} +: 8];

    always_comb begin
        chk_dup = 1'b0;
        for (int b = 0; b < rdf_pkg::MAX_SYMBOLS; b++) begin
            if ((5'(b) > {1'b0, chk_idx_reg}) && (5'(b) < base_len_reg)
                && (sym_all[b*8 +: 8] == chk_char)) begin
                chk_dup = 1'b1;
            end
        end
    end

    assign chk_bad  = chk_dup || (chk_char == rdf_pkg::CHAR_PLUS)
                      || (chk_char == rdf_pkg::CHAR_MINUS)
                      || (chk_char < rdf_pkg::CHAR_LOWEST)
                      || (chk_char > rdf_pkg::CHAR_HIGHEST);
    assign chk_done = ({1'b0, chk_idx_reg} == (base_len_reg - 5'd1));

    // Bit-serial restoring divider step
    assign div_shift = {rem_reg, q_reg[rdf_pkg::VALUE_W-1]};
    assign div_ge    = (div_shift >= base_len_reg);
    assign div_sub   = div_shift - base_len_reg;
    assign rem_next  = div_ge ? div_sub[3:0] : div_shift[3:0];
    assign q_next    = {q_reg[rdf_pkg::VALUE_W-2:0], div_ge};
    assign count_next = (count_reg == FULL_COUNT) ? count_reg : count_reg + CW'(1);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_last = (left_reg == CW'(1));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rdf_pkg::ST_IDLE: begin
                if (in_accept && len_ok) state_next = rdf_pkg::ST_CHECK;
            end
            rdf_pkg::ST_CHECK: begin
                if (chk_bad)       state_next = rdf_pkg::ST_IDLE;
                else if (chk_done) state_next = rdf_pkg::ST_DIV;
            end
            rdf_pkg::ST_DIV: begin
                if (div_last && (q_next == '0)) state_next = rdf_pkg::ST_EMIT_RD;
            end
            rdf_pkg::ST_EMIT_RD: begin
                state_next = rdf_pkg::ST_EMIT_LD;
            end
            rdf_pkg::ST_EMIT_LD: begin
                if (out_free) begin
                    state_next = emit_last ? rdf_pkg::ST_IDLE : rdf_pkg::ST_EMIT_RD;
                end
            end
            default: state_next = rdf_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_tready = 1'b0;
        div_last = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            rdf_pkg::ST_IDLE:    s_tready = 1'b1;
            rdf_pkg::ST_CHECK:   ;
            rdf_pkg::ST_DIV:     div_last = (bit_cnt_reg == 6'd63);
            rdf_pkg::ST_EMIT_RD: ;
            rdf_pkg::ST_EMIT_LD: out_load = out_free;
            default: ;
        endcase
    end

    assign in_accept = s_tvalid && s_tready;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= rdf_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            count_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load)      m_tvalid_reg <= 1'b1;
            else if (m_tready) m_tvalid_reg <= 1'b0;
            if (in_accept)     count_reg <= '0;
            else if (div_last) count_reg <= count_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            q_reg       <= s_tdata;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
            chk_idx_reg <= '0;
            wptr_reg    <= '0;
        end
        if (state_reg == rdf_pkg::ST_CHECK) begin
            chk_idx_reg <= chk_idx_reg + 4'd1;
        end
        if (state_reg == rdf_pkg::ST_DIV) begin
            q_reg       <= q_next;
            bit_cnt_reg <= bit_cnt_reg + 6'd1;
            rem_reg     <= div_last ? 4'd0 : rem_next;
        end
        // Digit finished: ring pointer advances, readback starts at newest digit
        if (div_last) begin
            wptr_reg  <= (wptr_reg == LAST_ADDR) ? '0 : wptr_reg + AW'(1);
            raddr_reg <= wptr_reg;
            left_reg  <= count_next;
            k_reg     <= '0;
        end
        if (out_load) begin
            raddr_reg  <= (raddr_reg == '0) ? LAST_ADDR : raddr_reg - AW'(1);
            left_reg   <= left_reg - CW'(1);
            k_reg      <= k_reg + rdf_pkg::POS_W'(1);
            m_char_reg <= sym_all[{rdata_reg, 3'b000} +: 8];
            m_pos_reg  <= k_reg;
            m_last_reg <= emit_last;
        end
    end

    // Digit memory: write on digit completion, registered read
    always_ff @(posedge aclk) begin
        if (div_last) begin
            digit_mem[wptr_reg] <= rem_next;
        end
        if (state_reg == rdf_pkg::ST_EMIT_RD) begin
            rdata_reg <= digit_mem[raddr_reg];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_pos_reg, m_char_reg};
    assign m_tlast  = m_last_reg;

    // Checks
    a_rem_below_radix: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rdf_pkg::ST_DIV) |-> ({1'b0, rem_reg} < base_len_reg))
        else $error("divider remainder not below radix");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_COUNT)
        else $error("digit count exceeds memory depth");

    a_emit_has_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == rdf_pkg::ST_EMIT_RD) || (state_reg == rdf_pkg::ST_EMIT_LD))
        |-> (left_reg != '0))
        else $error("emitting with no digits left");

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && emit_last) |=> (state_reg == rdf_pkg::ST_IDLE) && m_tvalid_reg && m_last_reg)
        else $error("final digit did not end the run");

endmodule
